[design/isometric_grid_segment_generator_assert.svh]
// Assertion macros used by the grid generator module.
`ifndef ISOMETRIC_GRID_SEGMENT_GENERATOR_ASSERT_SVH
`define ISOMETRIC_GRID_SEGMENT_GENERATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define IGSG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("igsg assertion failed");
`define IGSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("igsg assertion failed");
`else
`define IGSG_ASSERT(lbl, clk, rst_n, prop)
`define IGSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[design/igsg_pkg.sv]
package igsg_pkg;

  // Primitive families named by a request.
  typedef enum logic [2:0] {
    KIND_DOT   = 3'd0,
    KIND_HEDGE = 3'd1,
    KIND_VLINE = 3'd2,
    KIND_LDIAG = 3'd3,
    KIND_RDIAG = 3'd4
  } kind_e;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_PAGE_WIDTH  = 2'd0,
    REG_PAGE_HEIGHT = 2'd1,
    REG_RASTER      = 2'd2
  } reg_e;

  // sqrt(3)/2 in Q16.
  localparam logic [15:0] SQRT3_HALF_Q16 = 16'd56756;

  localparam int unsigned RASTER_BITS = 16;
  localparam int unsigned DIV_BITS    = 32;

  localparam logic [15:0] RESET_RASTER = 16'd3628;

endpackage

[design/igsg_if.sv]
// Request channel.
interface igsg_in_if #(parameter int INDEX_BITS = 12) ();
  logic                  valid;
  logic                  ready;
  logic [2:0]            kind;
  logic [INDEX_BITS-1:0] major_index;
  logic [INDEX_BITS-1:0] minor_index;

  modport source (output valid, kind, major_index, minor_index, input ready);
  modport sink (input valid, kind, major_index, minor_index, output ready);
endinterface

// Result channel.
interface igsg_out_if #(parameter int COORD_BITS = 20) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  logic                  valid_res;

  modport source (output valid, start_x, start_y, end_x, end_y, valid_res, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, valid_res, output ready);
endinterface

[design/igsg_div_cell.sv]
// One restoring division step: subtracts the divisor shifted by SH when it fits.
module igsg_div_cell #(
  parameter int RW = 36,
  parameter int DW = 32,
  parameter int SH = 0
) (
  input  logic          clk_i,
  input  logic [RW-1:0] rem_i,
  input  logic [DW-1:0] div_i,
  output logic [RW-1:0] rem_o,
  output logic          q_o
);

  localparam int EW = ((RW > DW + SH) ? RW : DW + SH) + 1;

  logic [EW-1:0] rem_e, dsh_e;
  logic          fit;
  logic [RW-1:0] rem_d, rem_q;
  logic          q_d, q_q;

  // Compare against the shifted divisor and keep the remainder.
  always_comb begin
    rem_e = EW'(rem_i);
    dsh_e = EW'(div_i) << SH;
    fit   = rem_e >= dsh_e;
    q_d   = fit;
    rem_d = fit ? RW'(rem_e - dsh_e) : rem_i;
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    q_q   <= q_d;
  end

  assign rem_o = rem_q;
  assign q_o   = q_q;

endmodule

[design/igsg_decode.sv]
// Turns a request into grid index endpoints and an existence flag.
module igsg_decode #(
  parameter int QB         = 21,
  parameter int INDEX_BITS = 12
) (
  input  logic [2:0]            kind_i,
  input  logic [INDEX_BITS-1:0] major_i,
  input  logic [INDEX_BITS-1:0] minor_i,
  input  logic [QB-1:0]         cols_i,
  input  logic [QB-1:0]         rows_i,
  output logic [QB:0]           x1_o,
  output logic [QB:0]           y1_o,
  output logic [QB:0]           x2_o,
  output logic [QB:0]           y2_o,
  output logic                  ok_o
);

  localparam int XW = QB + 1;

  logic [XW-1:0] c, r, d, hd, vd, diags, rowm, one, hc, vc, dh2, dv2, d2;
  logic          even, below_h, below_v;

  always_comb begin
    c       = XW'(cols_i);
    r       = XW'(rows_i);
    d       = XW'(major_i);
    one     = XW'(1);
    hc      = XW'(cols_i[0]);
    vc      = XW'(rows_i[0]);
    hd      = c >> 1;
    vd      = r >> 1;
    diags   = hd + vd;
    rowm    = XW'(minor_i) << 1;
    even    = ~major_i[0];
    below_h = d < hd;
    below_v = d < vd;
    d2      = d << 1;
    dh2     = (d - hd) << 1;
    dv2     = (d - vd) << 1;
    x1_o    = '0;
    y1_o    = '0;
    x2_o    = '0;
    y2_o    = '0;
    ok_o    = 1'b0;
    case (kind_i)
      igsg_pkg::KIND_DOT: begin
        ok_o = (d <= c) && (even ? (rowm + XW'(2) <= r) : (rowm <= r));
        x1_o = d;
        y1_o = rowm + XW'(even);
        x2_o = d;
        y2_o = rowm + XW'(even);
      end
      igsg_pkg::KIND_HEDGE: begin
        ok_o = d <= one;
        y1_o = major_i[0] ? r : '0;
        x2_o = c;
        y2_o = major_i[0] ? r : '0;
      end
      igsg_pkg::KIND_VLINE: begin
        ok_o = d <= c;
        x1_o = d;
        x2_o = d;
        y2_o = r;
      end
      igsg_pkg::KIND_LDIAG: begin
        ok_o = d < diags + (hc & vc);
        x1_o = below_h ? one + d2 : c;
        y1_o = below_h ? '0 : one + dh2 - hc;
        y2_o = below_v ? one + d2 : r;
        x2_o = below_v ? '0 : one + dv2 - vc;
      end
      igsg_pkg::KIND_RDIAG: begin
        ok_o = d < diags;
        x1_o = below_h ? c - (one + d2) - hc : '0;
        y1_o = below_h ? '0 : one + dh2;
        y2_o = below_v ? one + d2 + hc : r;
        x2_o = below_v ? c : c - (one + dv2) + vc - hc;
      end
      default: begin
        ok_o = 1'b0;
      end
    endcase
  end

endmodule

[design/isometric_grid_segment_generator.sv]
// Isometric grid segment generator. Each request on in_i yields one primitive
// on out_o, and a new request is taken every cycle while results drain.
// Column and row counts come from two rows of COORD_BITS+1 division cells that
// run continuously off the configuration registers; after reset and after
// every register write the block holds in_i.ready low while those rows settle.
// Results are in 1/256 point, saturated to the coordinate range, and all zero
// with valid_res low when the request names no existing primitive.
`include "isometric_grid_segment_generator_assert.svh"

module isometric_grid_segment_generator #(
  parameter int COORD_BITS = 20,
  parameter int INDEX_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  igsg_in_if.sink     in_i,
  igsg_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int C   = COORD_BITS;
  localparam int QB  = C + 1;
  localparam int XW  = QB + 1;
  localparam int RW  = C + 16;
  localparam int DW  = igsg_pkg::DIV_BITS;
  localparam int OW  = RW + 2;
  localparam int PW  = XW + 33;
  localparam int SW  = ((OW > PW) ? OW : PW) + 2;
  localparam int CW  = $clog2(QB + 2);
  localparam int RB  = igsg_pkg::RASTER_BITS;
  localparam logic [CW-1:0] SETTLE = CW'(QB + 1);

  // Configuration registers.
  logic [C-1:0]  width_q, height_q;
  logic [RB-1:0] raster_q;
  logic [CW-1:0] busy_q, busy_d;
  logic          cfg_wr;
  logic [1:0]    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= C'(152320);
      height_q <= C'(215552);
      raster_q <= igsg_pkg::RESET_RASTER;
    end else if (cfg_wr) begin
      case (cfg_idx)
        igsg_pkg::REG_PAGE_WIDTH:  width_q  <= C'(pwdata);
        igsg_pkg::REG_PAGE_HEIGHT: height_q <= C'(pwdata);
        igsg_pkg::REG_RASTER:      raster_q <= RB'(pwdata);
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (cfg_idx)
      igsg_pkg::REG_PAGE_WIDTH:  prdata = 32'(width_q);
      igsg_pkg::REG_PAGE_HEIGHT: prdata = 32'(height_q);
      igsg_pkg::REG_RASTER:      prdata = 32'(raster_q);
      default:                   prdata = '0;
    endcase
  end

  // Settling counter for the division rows.
  always_comb begin
    if (cfg_wr) begin
      busy_d = SETTLE;
    end else if (busy_q != '0) begin
      busy_d = busy_q - CW'(1);
    end else begin
      busy_d = busy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= SETTLE;
    end else begin
      busy_q <= busy_d;
    end
  end

  // Grid geometry derived from the registers.
  logic [C+1:0]  two_r;
  logic          empty;
  logic [C:0]    wdiff, hdiff;
  logic [RW-1:0] num_c, num_r;
  logic [DW-1:0] den_c, den_r;

  always_comb begin
    two_r = (C + 2)'(raster_q) << 1;
    empty = (raster_q == '0) || ((C + 2)'(width_q) < two_r) ||
            ((C + 2)'(height_q) < two_r);
    wdiff = (C + 1)'((C + 2)'(width_q) - two_r);
    hdiff = (C + 1)'((C + 2)'(height_q) - two_r);
    num_c = RW'(wdiff) << 16;
    num_r = RW'(hdiff) << 16;
    den_c = DW'(raster_q) * DW'(igsg_pkg::SQRT3_HALF_Q16);
    den_r = DW'(raster_q) << 15;
  end

  // Two rows of division cells, one quotient bit per cell.
  logic [RW-1:0] rem_c [QB+1];
  logic [RW-1:0] rem_r [QB+1];
  logic [QB-1:0] cols, rows;

  assign rem_c[0] = num_c;
  assign rem_r[0] = num_r;

  for (genvar k = 0; k < QB; k++) begin : g_cells
    igsg_div_cell #(.RW(RW), .DW(DW), .SH(QB - 1 - k)) u_col_cell (
      .clk_i (clk_i),
      .rem_i (rem_c[k]),
      .div_i (den_c),
      .rem_o (rem_c[k+1]),
      .q_o   (cols[QB-1-k])
    );
    igsg_div_cell #(.RW(RW), .DW(DW), .SH(QB - 1 - k)) u_row_cell (
      .clk_i (clk_i),
      .rem_i (rem_r[k]),
      .div_i (den_r),
      .rem_o (rem_r[k+1]),
      .q_o   (rows[QB-1-k])
    );
  end

  // Page minus content, in Q16.
  logic [OW-1:0] off_x, off_y, margin;

  assign margin = OW'(two_r) << 16;
  assign off_x  = OW'(rem_c[QB]) + margin;
  assign off_y  = OW'(rem_r[QB]) + margin;

  // Pipeline flow control.
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4       = out_o.ready | ~v4_q;
  assign rdy3       = rdy4 | ~v3_q;
  assign rdy2       = rdy3 | ~v2_q;
  assign rdy1       = rdy2 | ~v1_q;
  assign in_i.ready = rdy1 & (busy_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_i.valid & in_i.ready;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: index endpoints.
  logic [XW-1:0] x1, y1, x2, y2, x1_q, y1_q, x2_q, y2_q;
  logic          ok, ok1_q;

  igsg_decode #(.QB(QB), .INDEX_BITS(INDEX_BITS)) u_decode (
    .kind_i  (in_i.kind),
    .major_i (in_i.major_index),
    .minor_i (in_i.minor_index),
    .cols_i  (cols),
    .rows_i  (rows),
    .x1_o    (x1),
    .y1_o    (y1),
    .x2_o    (x2),
    .y2_o    (y2),
    .ok_o    (ok)
  );

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      x1_q  <= x1;
      y1_q  <= y1;
      x2_q  <= x2;
      y2_q  <= y2;
      ok1_q <= ok & ~empty;
    end
  end

  // Stage 2: scale indices by the raster spacing.
  logic [XW+15:0] px1_q, px2_q, py1_q, py2_q;
  logic           ok2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      px1_q <= (XW + 16)'(x1_q) * (XW + 16)'(raster_q);
      px2_q <= (XW + 16)'(x2_q) * (XW + 16)'(raster_q);
      py1_q <= (XW + 16)'(y1_q) * (XW + 16)'(raster_q);
      py2_q <= (XW + 16)'(y2_q) * (XW + 16)'(raster_q);
      ok2_q <= ok1_q;
    end
  end

  // Stage 3: horizontal positions times sqrt(3)/2.
  logic [XW+31:0] mx1_q, mx2_q;
  logic [XW+15:0] py1_3q, py2_3q;
  logic           ok3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      mx1_q  <= (XW + 32)'(px1_q) * (XW + 32)'(igsg_pkg::SQRT3_HALF_Q16);
      mx2_q  <= (XW + 32)'(px2_q) * (XW + 32)'(igsg_pkg::SQRT3_HALF_Q16);
      py1_3q <= py1_q;
      py2_3q <= py2_q;
      ok3_q  <= ok2_q;
    end
  end

  // Stage 4: center, round half up and saturate; zero when no primitive exists.
  function automatic logic [C-1:0] place(input logic [OW-1:0] off,
                                         input logic [SW-1:0] pos2);
    logic [SW-1:0] sum, sh;
    sum = SW'(off) + pos2 + SW'(65536);
    sh  = sum >> 17;
    if (sh > SW'({C{1'b1}})) begin
      place = {C{1'b1}};
    end else begin
      place = C'(sh);
    end
  endfunction

  logic [C-1:0] sx_q, sy_q, ex_q, ey_q;
  logic         vr_q;

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      vr_q <= ok3_q;
      if (ok3_q) begin
        sx_q <= place(off_x, SW'(mx1_q) << 1);
        sy_q <= place(off_y, SW'(py1_3q) << 16);
        ex_q <= place(off_x, SW'(mx2_q) << 1);
        ey_q <= place(off_y, SW'(py2_3q) << 16);
      end else begin
        sx_q <= '0;
        sy_q <= '0;
        ex_q <= '0;
        ey_q <= '0;
      end
    end
  end

  assign out_o.valid     = v4_q;
  assign out_o.start_x   = sx_q;
  assign out_o.start_y   = sy_q;
  assign out_o.end_x     = ex_q;
  assign out_o.end_y     = ey_q;
  assign out_o.valid_res = vr_q;

  // No request is taken while the division rows settle.
  `IGSG_ASSERT(a_no_accept_busy, clk_i, rst_ni, (in_i.valid && in_i.ready) |-> (busy_q == '0))
  // A register write restarts the settling window.
  `IGSG_ASSERT_NEXT(a_cfg_restart, clk_i, rst_ni, cfg_wr, busy_q != '0)
  // A missing primitive carries zero coordinates.
  `IGSG_ASSERT(a_invalid_zero, clk_i, rst_ni, (out_o.valid && !out_o.valid_res) |-> (out_o.start_x == '0 && out_o.start_y == '0 && out_o.end_x == '0 && out_o.end_y == '0))

endmodule
